@@ sv/quaternion_point_rotate_macros.svh @@
// Assertion macros for the quaternion point rotation checker.
// Plain text macros only, no dependencies.
`ifndef QUATERNION_POINT_ROTATE_MACROS_SVH
`define QUATERNION_POINT_ROTATE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset
`define QPR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define QPR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/qpr_pkg.sv @@
// Shared types and constants for the quaternion point rotation block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package qpr_pkg;

  // quaternion components are always 16 bits
  localparam int QUAT_W    = 16;
  localparam int NUM_REGS  = 7;
  localparam int REG_IDX_W = 3;

  // reset values: identity rotation, center at 1024
  localparam logic [QUAT_W-1:0] QUAT_W_RESET = 16'd16384;
  localparam int                CENTER_RESET = 1024;

  // configuration register map
  typedef enum logic [REG_IDX_W-1:0] {
    REG_QUAT_W,
    REG_QUAT_X,
    REG_QUAT_Y,
    REG_QUAT_Z,
    REG_CENTER_X,
    REG_CENTER_Y,
    REG_CENTER_Z
  } cfg_idx_t;

endpackage

`default_nettype wire

@@ sv/quaternion_point_rotate.sv @@
// Quaternion point rotation about a programmable center, six-stage pipeline.
// Depends on qpr_pkg.
//
//   channel | dir | handshake          | payload
//   s_*     | in  | s_tvalid/s_tready  | s_tdata: in_x, in_y, in_z
//   m_*     | out | m_tvalid/m_tready  | m_tdata: out_x, out_y, out_z; m_tuser: saturated
//   cfg_*   | in  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One word per cycle sustained while m_tready does not stall the pipe; an accepted
// word moves through the stage registers into the output register and leaves on m_tready.
// Stages: center subtract, q_v x s products, round c, w*c and q_v x c
// products, accumulate, round + center add + saturate.
// Reset clears the stage valid bits and loads the default registers.
// A stall at m_tready only holds stages that are occupied; bubbles close up.
`timescale 1ns / 1ps
`default_nettype none

module quaternion_point_rotate
  import qpr_pkg::*;
#(
  parameter int COORD_WIDTH    = 16,
  parameter int QUAT_FRAC_BITS = 14,
  localparam int TDATA_W = ((3 * COORD_WIDTH + 7) / 8) * 8,
  localparam int CFG_W   = (COORD_WIDTH > QUAT_W) ? COORD_WIDTH : QUAT_W
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // input words
  input  wire logic                 s_tvalid,
  output      logic                 s_tready,
  input  wire logic [TDATA_W-1:0]   s_tdata,    // in_x, in_y, in_z from bit 0
  // result words
  output      logic                 m_tvalid,
  input  wire logic                 m_tready,
  output      logic [TDATA_W-1:0]   m_tdata,    // out_x, out_y, out_z from bit 0
  output      logic [0:0]           m_tuser,    // saturated
  // register writes
  input  wire logic                 cfg_valid,
  output      logic                 cfg_ready,
  input  wire logic [REG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  localparam int CW   = COORD_WIDTH;
  localparam int F    = QUAT_FRAC_BITS;
  localparam int NST  = 6;
  localparam int SW   = CW + 1;                 // centered coordinate
  localparam int PW   = QUAT_W + SW;            // q * s
  localparam int CRW  = PW + 1;                 // cross product
  localparam int CCW  = CRW + 1 - F;            // rounded c
  localparam int PCW  = QUAT_W + CCW;           // q * c
  localparam int AW   = ((SW + F > PCW + 2) ? SW + F : PCW + 2) + 2;
  localparam int RW   = AW + 2 - F;             // rounded + center
  localparam int PADW = TDATA_W - 3 * CW;

  localparam logic signed [CRW:0] C_HALF  = (CRW + 1)'(1) << (F - 1);
  localparam logic signed [AW:0]  A_HALF  = (AW + 1)'(1) << (F - 1);
  localparam logic signed [RW-1:0] R_HI   = {{(RW - CW + 1){1'b0}}, {(CW - 1){1'b1}}};
  localparam logic signed [RW-1:0] R_LO   = {{(RW - CW + 1){1'b1}}, {(CW - 1){1'b0}}};

  // configuration registers
  logic signed [QUAT_W-1:0] quat_w;
  logic signed [QUAT_W-1:0] quat_v [3];
  logic signed [CW-1:0]     center [3];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      quat_w <= QUAT_W_RESET;
      for (int i = 0; i < 3; i++) begin
        quat_v[i] <= '0;
        center[i] <= CW'(CENTER_RESET);
      end
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        REG_QUAT_W:   quat_w    <= cfg_data[QUAT_W-1:0];
        REG_QUAT_X:   quat_v[0] <= cfg_data[QUAT_W-1:0];
        REG_QUAT_Y:   quat_v[1] <= cfg_data[QUAT_W-1:0];
        REG_QUAT_Z:   quat_v[2] <= cfg_data[QUAT_W-1:0];
        REG_CENTER_X: center[0] <= cfg_data[CW-1:0];
        REG_CENTER_Y: center[1] <= cfg_data[CW-1:0];
        REG_CENTER_Z: center[2] <= cfg_data[CW-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // stage valid bits and per-stage advance
  logic [NST-1:0] vld;
  logic [NST-1:0] en;

  always_comb begin
    en[NST-1] = !vld[NST-1] || m_tready;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= s_tvalid;
      for (int k = 1; k < NST; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  assign s_tready = en[0];
  assign m_tvalid = vld[NST-1];

  // load strobes per stage
  logic [NST-1:0] ld;
  assign ld = en & {vld[NST-2:0], s_tvalid};

  // pipeline payload
  logic signed [SW-1:0]  s1 [3];
  logic signed [SW-1:0]  s2 [3];
  logic signed [PW-1:0]  pa2 [3];
  logic signed [PW-1:0]  pb2 [3];
  logic signed [SW-1:0]  s3 [3];
  logic signed [CCW-1:0] c3 [3];
  logic signed [SW-1:0]  s4 [3];
  logic signed [PCW-1:0] wc4 [3];
  logic signed [PCW-1:0] qa4 [3];
  logic signed [PCW-1:0] qb4 [3];
  logic signed [AW-1:0]  acc5 [3];
  logic        [CW-1:0]  out_c [3];
  logic        [2:0]     sat_ax;
  logic                  out_sat;

  for (genvar i = 0; i < 3; i++) begin : g_axis
    localparam int J = (i + 1) % 3;
    localparam int K = (i + 2) % 3;

    logic signed [CW-1:0]  in_c;
    logic signed [CRW-1:0] cr;
    logic signed [CRW:0]   c_rnd;
    logic signed [AW:0]    a_rnd;
    logic signed [RW-1:0]  r_val;

    assign in_c  = s_tdata[i*CW +: CW];
    assign cr    = CRW'(pa2[i]) - CRW'(pb2[i]);
    assign c_rnd = (CRW + 1)'(cr) + C_HALF;
    assign a_rnd = (AW + 1)'(acc5[i]) + A_HALF;
    assign r_val = RW'($signed(a_rnd[AW:F])) + RW'(center[i]);
    assign sat_ax[i] = (r_val > R_HI) || (r_val < R_LO);

    always_ff @(posedge clk) begin
      // center subtract
      if (ld[0]) begin
        s1[i] <= SW'(in_c) - SW'(center[i]);
      end
      // q_v x s partial products
      if (ld[1]) begin
        s2[i]  <= s1[i];
        pa2[i] <= PW'(quat_v[J]) * PW'(s1[K]);
        pb2[i] <= PW'(quat_v[K]) * PW'(s1[J]);
      end
      // c = round(q_v x s)
      if (ld[2]) begin
        s3[i] <= s2[i];
        c3[i] <= $signed(c_rnd[CRW:F]);
      end
      // w*c and q_v x c partial products
      if (ld[3]) begin
        s4[i]  <= s3[i];
        wc4[i] <= PCW'(quat_w) * PCW'(c3[i]);
        qa4[i] <= PCW'(quat_v[J]) * PCW'(c3[K]);
        qb4[i] <= PCW'(quat_v[K]) * PCW'(c3[J]);
      end
      // s*2^F + 2*w*c + 2*(q_v x c)
      if (ld[4]) begin
        acc5[i] <= (AW'(s4[i]) <<< F) + (AW'(wc4[i]) <<< 1)
                   + ((AW'(qa4[i]) - AW'(qb4[i])) <<< 1);
      end
      // round, add center back, clamp
      if (ld[5]) begin
        if (r_val > R_HI) begin
          out_c[i] <= R_HI[CW-1:0];
        end else if (r_val < R_LO) begin
          out_c[i] <= R_LO[CW-1:0];
        end else begin
          out_c[i] <= r_val[CW-1:0];
        end
      end
    end

    assign m_tdata[i*CW +: CW] = out_c[i];
  end

  if (PADW > 0) begin : g_pad
    assign m_tdata[TDATA_W-1:3*CW] = '0;
  end

  always_ff @(posedge clk) begin
    if (ld[5]) out_sat <= |sat_ax;
  end

  assign m_tuser = out_sat;

endmodule

`default_nettype wire

@@ sv/qpr_checker.sv @@
// Port-level checks for quaternion_point_rotate, bound to the top level.
// Depends on quaternion_point_rotate_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "quaternion_point_rotate_macros.svh"

module qpr_checker #(
  parameter int COORD_WIDTH = 16,
  localparam int TDATA_W = ((3 * COORD_WIDTH + 7) / 8) * 8
) (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               s_tready,
  input wire logic               m_tvalid,
  input wire logic               m_tready,
  input wire logic [TDATA_W-1:0] m_tdata,
  input wire logic [0:0]         m_tuser,
  input wire logic               cfg_valid,
  input wire logic               cfg_ready
);

  localparam int CW = COORD_WIDTH;
  localparam logic [CW-1:0] C_MAX = {1'b0, {(CW - 1){1'b1}}};
  localparam logic [CW-1:0] C_MIN = {1'b1, {(CW - 1){1'b0}}};

  logic lim_x;
  logic lim_y;
  logic lim_z;

  assign lim_x = (m_tdata[CW-1:0] == C_MAX) || (m_tdata[CW-1:0] == C_MIN);
  assign lim_y = (m_tdata[2*CW-1:CW] == C_MAX) || (m_tdata[2*CW-1:CW] == C_MIN);
  assign lim_z = (m_tdata[3*CW-1:2*CW] == C_MAX) || (m_tdata[3*CW-1:2*CW] == C_MIN);

  // stalled result word holds
  `QPR_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result word changed under stall")
  // free output side means the pipe can take a word
  `QPR_ASSERT_NOW(a_in_ready, m_tready || !m_tvalid, s_tready, "input not ready with output free")
  // saturation flag only with a coordinate at a range limit
  `QPR_ASSERT_NOW(a_sat_limit, m_tvalid && m_tuser[0], lim_x || lim_y || lim_z, "saturated set without clamped coordinate")
  // register port never blocks
  `QPR_ASSERT_NOW(a_cfg_ready, cfg_valid, cfg_ready, "register write stalled")

endmodule

bind quaternion_point_rotate qpr_checker #(.COORD_WIDTH(COORD_WIDTH)) u_qpr_checker (
  .clk       (clk),
  .rst       (rst),
  .s_tready  (s_tready),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata),
  .m_tuser   (m_tuser),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready)
);

`default_nettype wire
